// File: src/e2q_pkg.sv
package e2q_pkg;

	localparam int Iters = 24;
	localparam int Cw = 34;

	localparam logic signed [Cw-1:0] PiQ30     = 34'sd3373259426;
	localparam logic signed [Cw-1:0] HalfPiQ30 = 34'sd1686629713;
	localparam logic signed [Cw-1:0] GainQ30   = 34'sd652032874;
	localparam logic signed [Cw-1:0] RndQ30    = 34'sd536870912;
	localparam logic signed [17:0]   Q14Max    = 18'sd16384;

	typedef logic signed [Cw-1:0] cw_t;

	typedef struct packed {
		logic signed [Cw-1:0] x;
		logic signed [Cw-1:0] y;
		logic signed [Cw-1:0] z;
		logic                 neg;
	} cstate_t;

	function automatic cw_t atan_q30(input logic [4:0] i);
		cw_t t;
		unique case (i)
			5'd0:  t = 34'sh3243F6A8;
			5'd1:  t = 34'sh1DAC6705;
			5'd2:  t = 34'sh0FADBAFC;
			5'd3:  t = 34'sh07F56EA6;
			5'd4:  t = 34'sh03FEAB76;
			5'd5:  t = 34'sh01FFD55B;
			5'd6:  t = 34'sh00FFFAAA;
			5'd7:  t = 34'sh007FFF55;
			5'd8:  t = 34'sh003FFFEA;
			5'd9:  t = 34'sh001FFFFD;
			5'd10: t = 34'sh000FFFFF;
			5'd11: t = 34'sh0007FFFF;
			5'd12: t = 34'sh0003FFFF;
			5'd13: t = 34'sh0001FFFF;
			5'd14: t = 34'sh0000FFFF;
			5'd15: t = 34'sh00007FFF;
			5'd16: t = 34'sh00003FFF;
			5'd17: t = 34'sh00001FFF;
			5'd18: t = 34'sh00000FFF;
			5'd19: t = 34'sh000007FF;
			5'd20: t = 34'sh000003FF;
			5'd21: t = 34'sh000001FF;
			5'd22: t = 34'sh000000FF;
			5'd23: t = 34'sh0000007F;
			default: t = '0;
		endcase
		return t;
	endfunction

endpackage

// File: src/e2q_cordic.sv
// Half-angle sin/cos, one item per cycle while en is high: fold stage plus 24 micro-rotation stages.
module e2q_cordic (
	input  logic                      clk,
	input  logic                      en,
	input  logic signed [15:0]        angle,
	output logic signed [e2q_pkg::Cw-1:0] cos_q,
	output logic signed [e2q_pkg::Cw-1:0] sin_q
);
	e2q_pkg::cstate_t st_s1 [e2q_pkg::Iters+1];
	e2q_pkg::cstate_t fold;
	e2q_pkg::cw_t     h;

	always_comb begin
		h = e2q_pkg::cw_t'(angle) <<< 16;
		fold = '{x: e2q_pkg::GainQ30, y: '0, z: h, neg: 1'b0};
		if (h > e2q_pkg::HalfPiQ30) begin
			fold.z = h - e2q_pkg::PiQ30;
			fold.neg = 1'b1;
		end else if (h < -e2q_pkg::HalfPiQ30) begin
			fold.z = h + e2q_pkg::PiQ30;
			fold.neg = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) st_s1[0] <= fold;
	end

	for (genvar i = 0; i < e2q_pkg::Iters; i++) begin : g_it
		e2q_pkg::cstate_t nx;
		always_comb begin
			nx = st_s1[i];
			if (!st_s1[i].z[e2q_pkg::Cw-1]) begin
				nx.x = st_s1[i].x - (st_s1[i].y >>> i);
				nx.y = st_s1[i].y + (st_s1[i].x >>> i);
				nx.z = st_s1[i].z - e2q_pkg::atan_q30(5'(i));
			end else begin
				nx.x = st_s1[i].x + (st_s1[i].y >>> i);
				nx.y = st_s1[i].y - (st_s1[i].x >>> i);
				nx.z = st_s1[i].z + e2q_pkg::atan_q30(5'(i));
			end
		end
		always_ff @(posedge clk) begin
			if (en) st_s1[i+1] <= nx;
		end
	end

	assign cos_q = st_s1[e2q_pkg::Iters].neg ? -st_s1[e2q_pkg::Iters].x
	                                         : st_s1[e2q_pkg::Iters].x;
	assign sin_q = st_s1[e2q_pkg::Iters].neg ? -st_s1[e2q_pkg::Iters].y
	                                         : st_s1[e2q_pkg::Iters].y;
endmodule

// File: src/e2q_mul.sv
// Registered Q30 multiply, rounding half up.
module e2q_mul (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [e2q_pkg::Cw-1:0] a,
	input  logic signed [e2q_pkg::Cw-1:0] b,
	output logic signed [e2q_pkg::Cw-1:0] p_q
);
	logic signed [2*e2q_pkg::Cw-1:0] full;
	assign full = a * b + (2*e2q_pkg::Cw)'(e2q_pkg::RndQ30);
	always_ff @(posedge clk) begin
		if (en) p_q <= e2q_pkg::Cw'(full >>> 30);
	end
endmodule

// File: src/euler_to_quaternion_unit.sv
// Euler (Z-Y-X) to unit quaternion. Angles in signed Q3.13 radians, results in
// signed Q1.14 saturated to +/-1. Fully pipelined: one transfer per cycle in and
// out, through fold, 24 CORDIC stages, two product stages, sum and output
// register. The pipeline advances whenever the output register is empty or
// being taken, so in_ready is high under that condition and a stall holds every stage.
module euler_to_quaternion_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] roll_angle,
	input  logic signed [15:0] pitch_angle,
	input  logic signed [15:0] yaw_angle,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] quat_w,
	output logic signed [15:0] quat_x,
	output logic signed [15:0] quat_y,
	output logic signed [15:0] quat_z
);
	localparam int Lat = e2q_pkg::Iters + 4; // stages before output register

	logic en;
	logic [Lat-1:0] vld_s1;
	e2q_pkg::cw_t cr, sr, cp, sp, cy, sy;
	e2q_pkg::cw_t cycp, sysp, cysp, sycp;
	e2q_pkg::cw_t cr_s2, sr_s2;
	e2q_pkg::cw_t t0, t1, t2, t3, t4, t5, t6, t7;
	e2q_pkg::cw_t w_s3, x_s3, y_s3, z_s3;

	// Output register is the only holding point; everything moves together.
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= '0;
			out_valid <= 1'b0;
		end else if (en) begin
			vld_s1    <= {vld_s1[Lat-2:0], in_valid};
			out_valid <= vld_s1[Lat-1];
		end
	end

	e2q_cordic u_roll  (.clk, .en, .angle(roll_angle),  .cos_q(cr), .sin_q(sr));
	e2q_cordic u_pitch (.clk, .en, .angle(pitch_angle), .cos_q(cp), .sin_q(sp));
	e2q_cordic u_yaw   (.clk, .en, .angle(yaw_angle),   .cos_q(cy), .sin_q(sy));

	// First product stage: yaw x pitch pairs; roll terms delayed to match.
	e2q_mul u_m0 (.clk, .en, .a(cy), .b(cp), .p_q(cycp));
	e2q_mul u_m1 (.clk, .en, .a(sy), .b(sp), .p_q(sysp));
	e2q_mul u_m2 (.clk, .en, .a(cy), .b(sp), .p_q(cysp));
	e2q_mul u_m3 (.clk, .en, .a(sy), .b(cp), .p_q(sycp));

	always_ff @(posedge clk) begin
		if (en) begin
			cr_s2 <= cr;
			sr_s2 <= sr;
		end
	end

	// Second product stage: times roll terms.
	e2q_mul u_m4 (.clk, .en, .a(cycp), .b(cr_s2), .p_q(t0));
	e2q_mul u_m5 (.clk, .en, .a(sysp), .b(sr_s2), .p_q(t1));
	e2q_mul u_m6 (.clk, .en, .a(cycp), .b(sr_s2), .p_q(t2));
	e2q_mul u_m7 (.clk, .en, .a(sysp), .b(cr_s2), .p_q(t3));
	e2q_mul u_m8 (.clk, .en, .a(cysp), .b(cr_s2), .p_q(t4));
	e2q_mul u_m9 (.clk, .en, .a(sycp), .b(sr_s2), .p_q(t5));
	e2q_mul u_m10 (.clk, .en, .a(sycp), .b(cr_s2), .p_q(t6));
	e2q_mul u_m11 (.clk, .en, .a(cysp), .b(sr_s2), .p_q(t7));

	always_ff @(posedge clk) begin
		if (en) begin
			w_s3 <= t0 + t1;
			x_s3 <= t2 - t3;
			y_s3 <= t4 + t5;
			z_s3 <= t6 - t7;
		end
	end

	function automatic logic signed [15:0] to_q14(input e2q_pkg::cw_t v);
		e2q_pkg::cw_t r;
		r = (v + e2q_pkg::cw_t'(32768)) >>> 16;
		if (r > e2q_pkg::cw_t'(e2q_pkg::Q14Max)) r = e2q_pkg::cw_t'(e2q_pkg::Q14Max);
		if (r < -e2q_pkg::cw_t'(e2q_pkg::Q14Max)) r = -e2q_pkg::cw_t'(e2q_pkg::Q14Max);
		return r[15:0];
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			quat_w <= to_q14(w_s3);
			quat_x <= to_q14(x_s3);
			quat_y <= to_q14(y_s3);
			quat_z <= to_q14(z_s3);
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(quat_w) && $stable(quat_z))
		else $error("result changed under stall");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("ready mismatch");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (quat_w <= 16'sd16384 && quat_w >= -16'sd16384))
		else $error("w out of range");
endmodule
